>>> hdl/dkc_pkg.sv
// Shared constants, width helpers and the stage select struct for the
// disk kernel coverage block. No dependencies.
package dkc_pkg;

    localparam int SUBSAMPLES     = 8;
    localparam int MAX_HALF_WIDTH = 16;

    localparam int RADIUS_W    = 8;
    localparam int RADIUS_FRAC = 4;
    localparam int OFFSET_W    = 6;
    localparam int COV_W       = 7;
    localparam int TOTAL_W     = 17;
    localparam int HALF_W      = 5;

    // radius code of one half pixel, and the rounding add for ceil(r - 1/2)
    localparam int SMALL_RADIUS = 2 ** (RADIUS_FRAC - 1);
    localparam int ROUND_ADD    = 2 ** (RADIUS_FRAC - 1) - 1;

    // distances carry a factor 8 against the radius: squares scale by 64
    localparam int SCALE_SHIFT = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic first;
        logic zero;
        logic full;
    } t_sel;

    function automatic int coord_max(input int s);
        return s * (2 * (2 ** (OFFSET_W - 1)) + 1);
    endfunction

    function automatic int coord_w(input int s);
        return $clog2(coord_max(s) + 1) + 1;
    endfunction

    function automatic int sq_w(input int s);
        return $clog2(coord_max(s) * coord_max(s) + 1);
    endfunction

    function automatic int rr_w(input int s);
        return $clog2(((2 ** RADIUS_W) - 1) * s * ((2 ** RADIUS_W) - 1) * s + 1);
    endfunction

    function automatic int cmp_w(input int s);
        return (sq_w(s) + 1 + SCALE_SHIFT > rr_w(s)) ? sq_w(s) + 1 + SCALE_SHIFT : rr_w(s);
    endfunction

    function automatic int cnt_w(input int n);
        return $clog2(n + 1);
    endfunction

endpackage

>>> hdl/dkc_sq_stage.sv
// First compute stage: subsample coordinates, their squares and the
// window / small-radius select flags. Depends on dkc_pkg.
module dkc_sq_stage #(
    parameter int SUB = dkc_pkg::SUBSAMPLES,
    parameter int MHW = dkc_pkg::MAX_HALF_WIDTH,
    localparam int CW  = dkc_pkg::coord_w(SUB),
    localparam int SQW = dkc_pkg::sq_w(SUB),
    localparam int HWW = dkc_pkg::cnt_w(MHW)
) (
    input  logic                                i_clk,
    input  logic                                i_ld,
    input  logic signed [dkc_pkg::OFFSET_W-1:0] i_x,
    input  logic signed [dkc_pkg::OFFSET_W-1:0] i_y,
    input  logic                                i_first,
    input  logic [dkc_pkg::RADIUS_W-1:0]        i_radius,
    input  logic [HWW-1:0]                      i_hw,
    output logic [SUB-1:0][SQW-1:0]             o_sqx,
    output logic [SUB-1:0][SQW-1:0]             o_sqy,
    output dkc_pkg::t_sel                       o_sel
);

    localparam int AW = (HWW > dkc_pkg::OFFSET_W) ? HWW : dkc_pkg::OFFSET_W;
    localparam logic signed [CW-1:0] KX = CW'(2 * SUB);

    logic signed [CW-1:0]               xs;
    logic signed [CW-1:0]               ys;
    logic [SUB-1:0][SQW-1:0]            n_sqx;
    logic [SUB-1:0][SQW-1:0]            n_sqy;
    logic [SUB-1:0][SQW-1:0]            r_sqx;
    logic [SUB-1:0][SQW-1:0]            r_sqy;
    logic [dkc_pkg::OFFSET_W-1:0]       ax;
    logic [dkc_pkg::OFFSET_W-1:0]       ay;
    logic                               half_or_less;
    logic                               center;
    logic                               outside;
    dkc_pkg::t_sel                      n_sel;
    dkc_pkg::t_sel                      r_sel;

    assign xs = CW'(i_x);
    assign ys = CW'(i_y);

    for (genvar m = 0; m < SUB; m++) begin : g_tap
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [2*CW-1:0] px;
        logic signed [2*CW-1:0] py;
        assign cx = xs * KX + CW'(2 * m + 1 - SUB);
        assign cy = ys * KX + CW'(2 * m + 1 - SUB);
        assign px = cx * cx;
        assign py = cy * cy;
        assign n_sqx[m] = SQW'(px);
        assign n_sqy[m] = SQW'(py);
    end

    // magnitude of the most negative offset wraps to its unsigned value
    assign ax = i_x[dkc_pkg::OFFSET_W-1] ? dkc_pkg::OFFSET_W'(-i_x) : dkc_pkg::OFFSET_W'(i_x);
    assign ay = i_y[dkc_pkg::OFFSET_W-1] ? dkc_pkg::OFFSET_W'(-i_y) : dkc_pkg::OFFSET_W'(i_y);

    assign half_or_less = i_radius <= dkc_pkg::RADIUS_W'(dkc_pkg::SMALL_RADIUS);
    assign center  = (i_x == '0) && (i_y == '0);
    assign outside = (AW'(ax) > AW'(i_hw)) || (AW'(ay) > AW'(i_hw));

    always_comb begin
        n_sel.first = i_first;
        n_sel.full  = half_or_less && center;
        n_sel.zero  = half_or_less ? !center : outside;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
            r_sel <= n_sel;
        end
    end

    assign o_sqx = r_sqx;
    assign o_sqy = r_sqy;
    assign o_sel = r_sel;

endmodule

>>> hdl/dkc_cmp_stage.sv
// Second compute stage: all subsample distance tests against the squared
// radius, reduced to one count per subsample row. Depends on dkc_pkg.
module dkc_cmp_stage #(
    parameter int SUB = dkc_pkg::SUBSAMPLES,
    localparam int SQW = dkc_pkg::sq_w(SUB),
    localparam int RW  = dkc_pkg::rr_w(SUB),
    localparam int RCW = dkc_pkg::cnt_w(SUB)
) (
    input  logic                    i_clk,
    input  logic                    i_ld,
    input  logic [SUB-1:0][SQW-1:0] i_sqx,
    input  logic [SUB-1:0][SQW-1:0] i_sqy,
    input  logic [RW-1:0]           i_rr,
    input  dkc_pkg::t_sel           i_sel,
    output logic [SUB-1:0][RCW-1:0] o_rows,
    output dkc_pkg::t_sel           o_sel
);

    localparam int CPW = dkc_pkg::cmp_w(SUB);

    logic [SUB-1:0][RCW-1:0] n_rows;
    logic [SUB-1:0][RCW-1:0] r_rows;
    dkc_pkg::t_sel           r_sel;

    always_comb begin
        logic [SQW:0]   d_sum;
        logic [CPW-1:0] scaled;
        logic [RCW-1:0] cnt;
        for (int n = 0; n < SUB; n++) begin
            cnt = '0;
            for (int m = 0; m < SUB; m++) begin
                d_sum  = (SQW + 1)'(i_sqx[m]) + (SQW + 1)'(i_sqy[n]);
                scaled = CPW'(d_sum) << dkc_pkg::SCALE_SHIFT;
                if (scaled <= CPW'(i_rr)) begin
                    cnt = cnt + 1'b1;
                end
            end
            n_rows[n] = cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_rows <= n_rows;
            r_sel  <= i_sel;
        end
    end

    assign o_rows = r_rows;
    assign o_sel  = r_sel;

endmodule

>>> hdl/dkc_acc_stage.sv
// Result stage: row counts summed to the coverage, the saturating running
// total, and the result register. Depends on dkc_pkg.
module dkc_acc_stage #(
    parameter int SUB = dkc_pkg::SUBSAMPLES,
    parameter int MHW = dkc_pkg::MAX_HALF_WIDTH,
    localparam int RCW = dkc_pkg::cnt_w(SUB),
    localparam int HWW = dkc_pkg::cnt_w(MHW)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ld,
    input  logic [SUB-1:0][RCW-1:0]            i_rows,
    input  dkc_pkg::t_sel                      i_sel,
    input  logic [HWW-1:0]                     i_hw,
    output logic [dkc_pkg::COV_W-1:0]          o_coverage,
    output logic [dkc_pkg::TOTAL_W-1:0]        o_running_total,
    output logic [dkc_pkg::HALF_W-1:0]         o_half_width
);

    localparam int NW = dkc_pkg::cnt_w(SUB * SUB);
    localparam int AW = dkc_pkg::TOTAL_W + 1;

    logic [NW-1:0]               sum;
    logic [NW-1:0]               n_cov;
    logic [AW-1:0]               acc;
    logic [dkc_pkg::TOTAL_W-1:0] base;
    logic [dkc_pkg::TOTAL_W-1:0] n_total;
    logic [dkc_pkg::TOTAL_W-1:0] r_total;
    logic [NW-1:0]               r_cov;
    logic [HWW-1:0]              r_hw;

    always_comb begin
        sum = '0;
        for (int n = 0; n < SUB; n++) begin
            sum = sum + NW'(i_rows[n]);
        end
    end

    always_comb begin
        priority if (i_sel.zero) begin
            n_cov = '0;
        end else if (i_sel.full) begin
            n_cov = NW'(SUB * SUB);
        end else begin
            n_cov = sum;
        end
    end

    // restart on the first pixel, otherwise add and clip at full scale
    assign base    = i_sel.first ? '0 : r_total;
    assign acc     = AW'(base) + AW'(n_cov);
    assign n_total = (acc > AW'(dkc_pkg::TOTAL_MAX)) ? dkc_pkg::TOTAL_MAX
                                                     : acc[dkc_pkg::TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_ld) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_cov <= n_cov;
            r_hw  <= i_hw;
        end
    end

    assign o_coverage      = dkc_pkg::COV_W'(r_cov);
    assign o_running_total = r_total;
    assign o_half_width    = dkc_pkg::HALF_W'(r_hw);

endmodule

>>> hdl/disk_kernel_coverage.sv
// Top level of the supersampled disk kernel coverage block: handshake,
// radius register and the three compute stages. Depends on dkc_pkg and the
// dkc_sq_stage, dkc_cmp_stage and dkc_acc_stage modules.
//
// One item carries a kernel pixel offset and a first-pixel flag; its result
// gives the number of subsample centres of that pixel inside the disk set by
// the Q4.4 radius register, the running total since the last first pixel
// (saturating at its full scale), and the kernel half-width ceil(r - 1/2).
// The block takes one item every clock cycle while o_stall is low and has no
// internal loop: an item passes the input register, the square stage, the
// compare stage and the result register, where its result shows on o_valid,
// and up to four items are in flight. A held i_stall fills the stages back
// toward the input, and o_stall rises only once every stage holds an item.
// Write the radius only while no item is in flight; the derived squared
// radius passes r_qq and then r_rr after the write, in time for an item
// accepted right after it. No clearing pass is needed.
module disk_kernel_coverage #(
    parameter int SUBSAMPLES     = dkc_pkg::SUBSAMPLES,
    parameter int MAX_HALF_WIDTH = dkc_pkg::MAX_HALF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dkc_pkg::RADIUS_W-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [dkc_pkg::OFFSET_W-1:0] i_offset_x,
    input  logic signed [dkc_pkg::OFFSET_W-1:0] i_offset_y,
    input  logic                                i_first_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dkc_pkg::COV_W-1:0]           o_coverage,
    output logic [dkc_pkg::TOTAL_W-1:0]         o_running_total,
    output logic [dkc_pkg::HALF_W-1:0]          o_half_width
);

    localparam int SQW = dkc_pkg::sq_w(SUBSAMPLES);
    localparam int RW  = dkc_pkg::rr_w(SUBSAMPLES);
    localparam int RCW = dkc_pkg::cnt_w(SUBSAMPLES);
    localparam int HWW = dkc_pkg::cnt_w(MAX_HALF_WIDTH);
    localparam int QW  = dkc_pkg::RADIUS_W + 1;
    localparam int HCW = (QW > HWW) ? QW : HWW;

    // radius register and the values derived from it
    logic [dkc_pkg::RADIUS_W-1:0]   r_radius;
    logic [2*dkc_pkg::RADIUS_W-1:0] r_qq;
    logic [RW-1:0]                  r_rr;
    logic [HWW-1:0]                 r_hw;
    logic [HWW-1:0]                 n_hw;
    logic [QW-1:0]                  rounded;
    logic [QW-1:0]                  hq;

    // input register
    logic signed [dkc_pkg::OFFSET_W-1:0] r_x;
    logic signed [dkc_pkg::OFFSET_W-1:0] r_y;
    logic                                r_first;

    // per-stage valid bits and load enables
    logic r_v_in;
    logic r_v_sq;
    logic r_v_cmp;
    logic r_v_out;
    logic free_in;
    logic free_sq;
    logic free_cmp;
    logic free_out;

    logic [SUBSAMPLES-1:0][SQW-1:0] sqx;
    logic [SUBSAMPLES-1:0][SQW-1:0] sqy;
    logic [SUBSAMPLES-1:0][RCW-1:0] rows;
    dkc_pkg::t_sel                  sel_sq;
    dkc_pkg::t_sel                  sel_cmp;

    // hold the radius; derive the squared radius through r_qq and r_rr, the half-width through r_hw
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    assign rounded = QW'(r_radius) + QW'(dkc_pkg::ROUND_ADD);
    assign hq      = rounded >> dkc_pkg::RADIUS_FRAC;

    always_comb begin
        priority if (r_radius <= dkc_pkg::RADIUS_W'(dkc_pkg::SMALL_RADIUS)) begin
            n_hw = '0;
        end else if (HCW'(hq) > HCW'(MAX_HALF_WIDTH)) begin
            n_hw = HWW'(MAX_HALF_WIDTH);
        end else begin
            n_hw = HWW'(hq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qq <= '0;
            r_rr <= '0;
            r_hw <= '0;
        end else begin
            r_qq <= r_radius * r_radius;
            r_rr <= RW'(RW'(r_qq) * RW'(SUBSAMPLES * SUBSAMPLES));
            r_hw <= n_hw;
        end
    end

    // a stage may load when empty or when its contents move on
    assign free_out = !r_v_out || !i_stall;
    assign free_cmp = !r_v_cmp || free_out;
    assign free_sq  = !r_v_sq  || free_cmp;
    assign free_in  = !r_v_in  || free_sq;
    assign o_stall  = !free_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_sq  <= 1'b0;
            r_v_cmp <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (free_in) begin
                r_v_in <= i_valid;
            end
            if (free_sq) begin
                r_v_sq <= r_v_in;
            end
            if (free_cmp) begin
                r_v_cmp <= r_v_sq;
            end
            if (free_out) begin
                r_v_out <= r_v_cmp;
            end
        end
    end

    // capture the item; bubbles need not load payload
    always_ff @(posedge i_clk) begin
        if (free_in && i_valid) begin
            r_x     <= i_offset_x;
            r_y     <= i_offset_y;
            r_first <= i_first_pixel;
        end
    end

    dkc_sq_stage #(
        .SUB (SUBSAMPLES),
        .MHW (MAX_HALF_WIDTH)
    ) u_sq (
        .i_clk    (i_clk),
        .i_ld     (free_sq && r_v_in),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_first  (r_first),
        .i_radius (r_radius),
        .i_hw     (r_hw),
        .o_sqx    (sqx),
        .o_sqy    (sqy),
        .o_sel    (sel_sq)
    );

    dkc_cmp_stage #(
        .SUB (SUBSAMPLES)
    ) u_cmp (
        .i_clk  (i_clk),
        .i_ld   (free_cmp && r_v_sq),
        .i_sqx  (sqx),
        .i_sqy  (sqy),
        .i_rr   (r_rr),
        .i_sel  (sel_sq),
        .o_rows (rows),
        .o_sel  (sel_cmp)
    );

    // the running total advances only when a real item enters the result
    dkc_acc_stage #(
        .SUB (SUBSAMPLES),
        .MHW (MAX_HALF_WIDTH)
    ) u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ld            (free_out && r_v_cmp),
        .i_rows          (rows),
        .i_sel           (sel_cmp),
        .i_hw            (r_hw),
        .o_coverage      (o_coverage),
        .o_running_total (o_running_total),
        .o_half_width    (o_half_width)
    );

    assign o_valid = r_v_out;

endmodule

>>> hdl/dkc_checker.sv
// Port-level checks for disk_kernel_coverage, attached by the bind below.
// Depends on dkc_pkg and the disk_kernel_coverage top level.
module dkc_checker #(
    parameter int SUB = dkc_pkg::SUBSAMPLES
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [dkc_pkg::COV_W-1:0]           o_coverage,
    input logic [dkc_pkg::TOTAL_W-1:0]         o_running_total,
    input logic [dkc_pkg::HALF_W-1:0]          o_half_width
);

    localparam logic [dkc_pkg::COV_W-1:0] FULL_COV = dkc_pkg::COV_W'(SUB * SUB);

    // no result survives a reset
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result holds its value
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_coverage)
            && $stable(o_running_total) && $stable(o_half_width))
        else $error("stalled result changed");

    // the input stalls only behind a stalled result
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with the result side free");

    // the total always includes the pixel it is reported with
    a_total_covers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_running_total >= dkc_pkg::TOTAL_W'(o_coverage))
        else $error("running total below coverage");

    // zero half-width means a single-pixel kernel: empty or fully covered
    a_small_kernel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_half_width == '0) |-> (o_coverage == '0) || (o_coverage == FULL_COV))
        else $error("partial coverage with zero half-width");

endmodule

bind disk_kernel_coverage dkc_checker #(
    .SUB (SUBSAMPLES)
) u_dkc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_coverage      (o_coverage),
    .o_running_total (o_running_total),
    .o_half_width    (o_half_width)
);

>>> dv/tb_disk_kernel_coverage.sv
// Self-checking testbench for disk_kernel_coverage: directed and random pixel
// traffic over many radius settings, checked against an in-bench predictor.
// Depends on dkc_pkg and the disk_kernel_coverage RTL.
`timescale 1ns / 1ps

module tb_disk_kernel_coverage;

    // Random traffic target and the length of the fully covered run that
    // builds up a large running total without a clear.
    localparam int RANDOM_PIXELS     = 1220;
    localparam int LONG_TOTAL_PIXELS = 300;
    localparam int QUIET_TAIL        = 200;
    localparam int SETTLE_CYCLES     = 10;

    typedef struct packed {
        logic [dkc_pkg::COV_W-1:0]   coverage;
        logic [dkc_pkg::TOTAL_W-1:0] running_total;
        logic [dkc_pkg::HALF_W-1:0]  half_width;
    } t_pixel_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [dkc_pkg::RADIUS_W-1:0]        i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [dkc_pkg::OFFSET_W-1:0] i_offset_x = '0;
    logic signed [dkc_pkg::OFFSET_W-1:0] i_offset_y = '0;
    logic                                i_first_pixel = 1'b0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic [dkc_pkg::COV_W-1:0]           o_coverage;
    logic [dkc_pkg::TOTAL_W-1:0]         o_running_total;
    logic [dkc_pkg::HALF_W-1:0]          o_half_width;

    // Predictor state: the radius register and the running coverage total.
    logic [dkc_pkg::RADIUS_W-1:0] disk_radius = '0;
    logic [dkc_pkg::TOTAL_W-1:0]  coverage_total = '0;

    t_pixel_result pixel_results_due[$];

    int  pixels_sent = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  radius_writes = 0;
    int  saturations = 0;
    bit  idle_on = 1'b0;
    int  stall_left = 0;

    disk_kernel_coverage dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_offset_x      (i_offset_x),
        .i_offset_y      (i_offset_y),
        .i_first_pixel   (i_first_pixel),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_coverage      (o_coverage),
        .o_running_total (o_running_total),
        .o_half_width    (o_half_width)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Kernel half-width ceil(r - 1/2) for a Q4.4 radius, zero up to one half,
    // clamped to the largest window the block supports.
    function automatic int half_width_for(input int q);
        int hw;
        hw = (q > dkc_pkg::SMALL_RADIUS) ?
             (q + dkc_pkg::ROUND_ADD) >> dkc_pkg::RADIUS_FRAC : 0;
        if (hw > dkc_pkg::MAX_HALF_WIDTH) hw = dkc_pkg::MAX_HALF_WIDTH;
        return hw;
    endfunction

    // Count subsample centres inside the disk. Work in units of 1/(2S) pixel
    // so every centre is an odd integer; the radius then carries a factor of
    // S/8 and the squared test picks up a factor of 64 on the distance side.
    function automatic int subsamples_inside(input int x, input int y, input int q);
        int rr;
        int cx;
        int cy;
        int hits;
        rr = (q * dkc_pkg::SUBSAMPLES) * (q * dkc_pkg::SUBSAMPLES);
        hits = 0;
        for (int n = 0; n < dkc_pkg::SUBSAMPLES; n++) begin
            cy = 2 * dkc_pkg::SUBSAMPLES * y - dkc_pkg::SUBSAMPLES + 2 * n + 1;
            for (int m = 0; m < dkc_pkg::SUBSAMPLES; m++) begin
                cx = 2 * dkc_pkg::SUBSAMPLES * x - dkc_pkg::SUBSAMPLES + 2 * m + 1;
                if (((cx * cx + cy * cy) << dkc_pkg::SCALE_SHIFT) <= rr) hits++;
            end
        end
        return hits;
    endfunction

    // Work out the result for one accepted pixel and advance the running total.
    function automatic t_pixel_result coverage_of_pixel(
        input logic signed [dkc_pkg::OFFSET_W-1:0] ox,
        input logic signed [dkc_pkg::OFFSET_W-1:0] oy,
        input logic                                first_px
    );
        t_pixel_result r;
        int x;
        int y;
        int q;
        int hw;
        int cov;
        logic [dkc_pkg::TOTAL_W:0] sum;
        x = int'(ox);
        y = int'(oy);
        q = int'(disk_radius);
        hw = half_width_for(q);
        // Radius of one half or less: only the centre pixel, fully covered.
        if (q <= dkc_pkg::SMALL_RADIUS)
            cov = (x == 0 && y == 0) ? dkc_pkg::SUBSAMPLES * dkc_pkg::SUBSAMPLES : 0;
        else if ((x < 0 ? -x : x) > hw || (y < 0 ? -y : y) > hw)
            cov = 0;
        else
            cov = subsamples_inside(x, y, q);
        if (first_px) coverage_total = '0;
        sum = {1'b0, coverage_total} + (dkc_pkg::TOTAL_W + 1)'(cov);
        if (sum > {1'b0, dkc_pkg::TOTAL_MAX}) begin
            coverage_total = dkc_pkg::TOTAL_MAX;
            saturations++;
        end else begin
            coverage_total = sum[dkc_pkg::TOTAL_W-1:0];
        end
        r.coverage      = cov[dkc_pkg::COV_W-1:0];
        r.running_total = coverage_total;
        r.half_width    = hw[dkc_pkg::HALF_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH at %0t, result %0d: %s expected %0d, got %0d",
                 $realtime, results_seen, what, want, got);
        mismatches++;
    endtask

    // Result side: check each accepted result against the oldest pixel still
    // owed, then pick the stall for the next cycle. Stall comes in bursts while
    // idling is on; a burst in progress runs out on its own.
    always @(posedge i_clk) begin : result_side
        t_pixel_result want;
        logic next_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_results_due.size() == 0) begin
                report_mismatch("result with no pixel outstanding, coverage",
                                0, 32'(o_coverage));
            end else begin
                want = pixel_results_due.pop_front();
                if (o_coverage !== want.coverage)
                    report_mismatch("coverage", 32'(want.coverage), 32'(o_coverage));
                if (o_running_total !== want.running_total)
                    report_mismatch("running total", 32'(want.running_total),
                                    32'(o_running_total));
                if (o_half_width !== want.half_width)
                    report_mismatch("half width", 32'(want.half_width),
                                    32'(o_half_width));
            end
            results_seen++;
        end
        if (!i_rst_n) begin
            next_stall = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            next_stall = 1'b1;
        end else if (idle_on && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(1, 18) - 1;
            next_stall = 1'b1;
        end else begin
            next_stall = 1'b0;
        end
        i_stall <= next_stall;
    end

    // Present one pixel and hold it until accepted. Valid is left high on
    // return so a following pixel can go out back to back; drop it with
    // drain_pixels before anything else touches the block.
    task automatic send_pixel(input int ox, input int oy, input bit first_px);
        int gap;
        logic signed [dkc_pkg::OFFSET_W-1:0] px;
        logic signed [dkc_pkg::OFFSET_W-1:0] py;
        px = ox[dkc_pkg::OFFSET_W-1:0];
        py = oy[dkc_pkg::OFFSET_W-1:0];
        if (idle_on && $urandom_range(0, 99) < 12) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_offset_x    <= px;
        i_offset_y    <= py;
        i_first_pixel <= first_px;
        do @(posedge i_clk); while (o_stall);
        pixel_results_due.push_back(coverage_of_pixel(px, py, first_px));
        pixels_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_pixels();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pixel_results_due.size() != 0);
    endtask

    // Write the radius only with the pipe empty; every pixel gives a result,
    // so an empty queue means no item is in flight.
    task automatic write_radius(input int q);
        drain_pixels();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= q[dkc_pkg::RADIUS_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        disk_radius = q[dkc_pkg::RADIUS_W-1:0];
        radius_writes++;
    endtask

    // Raster over the window plus a one pixel margin, clearing the total on
    // the first pixel, the way a kernel is built.
    task automatic scan_kernel(input int hw);
        for (int y = -hw - 1; y <= hw + 1; y++)
            for (int x = -hw - 1; x <= hw + 1; x++)
                send_pixel(x, y, (x == -hw - 1 && y == -hw - 1));
    endtask

    // Radius at or below one half: the centre pixel alone, fully covered.
    // Start on the reset radius, then the largest small code.
    task automatic test_small_radius();
        send_pixel(0, 0, 1'b1);
        send_pixel(31, 31, 1'b0);
        send_pixel(-32, -32, 1'b0);
        send_pixel(0, 1, 1'b0);
        write_radius(dkc_pkg::SMALL_RADIUS);
        send_pixel(0, 0, 1'b1);
        send_pixel(-1, 0, 1'b0);
    endtask

    // Just past one half the count is exact: the centre is only partly
    // covered until the radius reaches its corner subsample centres.
    task automatic test_just_over_half();
        write_radius(dkc_pkg::SMALL_RADIUS + 1);
        send_pixel(0, 0, 1'b1);
        send_pixel(1, 0, 1'b0);
        write_radius(dkc_pkg::SMALL_RADIUS + 3);
        send_pixel(0, 0, 1'b1);
        send_pixel(0, -1, 1'b0);
        write_radius(dkc_pkg::SMALL_RADIUS + 4);
        send_pixel(0, 0, 1'b1);
    endtask

    // Window edges at the largest radius and at a mid radius, with offsets
    // past the half-width and at the ends of the offset range.
    task automatic test_window_edges();
        write_radius(255);
        send_pixel(16, 16, 1'b1);
        send_pixel(-16, -16, 1'b0);
        send_pixel(17, 0, 1'b0);
        send_pixel(0, -17, 1'b0);
        send_pixel(31, -32, 1'b0);
        send_pixel(0, 0, 1'b0);
        write_radius(40);
        send_pixel(2, -2, 1'b1);
        send_pixel(3, 0, 1'b0);
        send_pixel(-2, 3, 1'b0);
    endtask

    // Feed fully covered pixels without a clear to build a large running
    // total, then check that a first pixel clears it.
    task automatic test_long_total();
        write_radius(255);
        idle_on = 1'b1;
        for (int i = 0; i < LONG_TOTAL_PIXELS; i++)
            send_pixel($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10, i == 0);
        send_pixel(0, 0, 1'b1);
    endtask

    // Phases of random traffic, each on its own radius. Most pixels come as
    // kernel scans or bursts inside the window; the rest is full-range noise.
    // The closing stretch runs with no idling on either side.
    task automatic test_random_kernels();
        int start;
        int phase;
        int q;
        int hw;
        int pick;
        int phase_end;
        phase = 0;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            if (phase == 0)
                q = 0;
            else if (phase == 1)
                q = 255;
            else if ($urandom_range(0, 3) == 0)
                q = $urandom_range(0, 255);
            else
                q = $urandom_range(0, 90);
            write_radius(q);
            idle_on = (pixels_sent - start < RANDOM_PIXELS - QUIET_TAIL) &&
                      ($urandom_range(0, 3) != 0);
            hw = half_width_for(q);
            phase_end = pixels_sent + 150;
            if (phase_end > start + RANDOM_PIXELS)
                phase_end = start + RANDOM_PIXELS;
            while (pixels_sent < phase_end) begin
                if (pixels_sent - start >= RANDOM_PIXELS - QUIET_TAIL)
                    idle_on = 1'b0;
                pick = $urandom_range(0, 9);
                if (pick < 4 && hw <= 5 &&
                    phase_end - pixels_sent >= (2 * hw + 3) * (2 * hw + 3)) begin
                    scan_kernel(hw);
                end else if (pick < 8) begin
                    for (int i = 0; i < 24; i++)
                        send_pixel($urandom_range(0, 2 * hw + 2) - hw - 1,
                                   $urandom_range(0, 2 * hw + 2) - hw - 1,
                                   i == 0 || $urandom_range(0, 15) == 0);
                end else begin
                    for (int i = 0; i < 12; i++)
                        send_pixel($urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 9) == 0);
                end
            end
            phase++;
        end
        idle_on = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_radius();
        test_just_over_half();
        test_window_edges();
        test_long_total();
        test_random_kernels();

        // Hold off past the last result to catch strays.
        drain_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d pixels and %0d results over %0d radius writes;",
                 pixels_sent, results_seen, radius_writes);
        $display("running total reached full scale on %0d pixels, %0d mismatches.",
                 saturations, mismatches);
        if (mismatches == 0 && pixel_results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Backstop: far beyond the slowest legal run with full idling.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", pixel_results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
